FILE: hdl/nfal_pkg.sv
package nfal_pkg;

    localparam int DW     = 32;
    localparam int MUL_W  = (DW + 1 > 33) ? DW + 1 : 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [2:0] CFG_DESIRED_FORCE      = 3'd0;
    localparam logic [2:0] CFG_FILTER_ALPHA       = 3'd1;
    localparam logic [2:0] CFG_TICK_PERIOD        = 3'd2;
    localparam logic [2:0] CFG_ADM_GAIN           = 3'd3;
    localparam logic [2:0] CFG_VELOCITY_LIMIT     = 3'd4;
    localparam logic [2:0] CFG_DISPLACEMENT_LIMIT = 3'd5;

    localparam logic [30:0] VEL_FLOOR = 31'd268;

    typedef logic signed [PROD_W:0] t_wide;

    localparam t_wide DW_MAX = t_wide'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam t_wide DW_MIN = -DW_MAX - t_wide'(1);
    localparam t_wide RND16  = t_wide'(64'sd1 <<< 15);
    localparam t_wide RND32  = t_wide'(64'sd1 <<< 31);

    typedef struct packed {
        logic signed [31:0] desired_force;
        logic [16:0]        filter_alpha;
        logic [31:0]        tick_period;
        logic [30:0]        adm_gain;
        logic [30:0]        velocity_limit;
        logic [30:0]        displacement_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] force_sample;
        logic               restart;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    function automatic logic signed [DW-1:0] sat_dw(input t_wide v);
        logic signed [DW-1:0] r;
        if (v > DW_MAX) begin
            r = DW'(DW_MAX);
        end else if (v < DW_MIN) begin
            r = DW'(DW_MIN);
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_sym(input t_wide v, input logic [30:0] lim);
        t_wide l;
        logic signed [31:0] r;
        l = t_wide'($signed({1'b0, lim}));
        if (v > l) begin
            r = 32'(l);
        end else if (v < -l) begin
            r = 32'(-l);
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

FILE: hdl/nfal_queue.sv
module nfal_queue
    import nfal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] force_sample
    input  logic [0:0]  s_axis_tuser,  // [0] restart
    output t_queue_out  o_head,
    input  logic        i_pop
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    t_item      in_item;

    assign s_axis_tready = (r_count != 2'd2);
    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = i_pop && (r_count != 2'd0);

    assign in_item.force_sample = $signed(s_axis_tdata);
    assign in_item.restart      = s_axis_tuser[0];

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: hdl/nfal_core.sv
module nfal_core
    import nfal_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  t_queue_out   i_head,
    output logic         o_pop,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] filtered_force, [63:32] error,
    // [95:64] velocity, [127:96] normal_displacement
    output logic [127:0] m_axis_tdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL_F = 4'd1;
    localparam logic [3:0] S_FILT  = 4'd2;
    localparam logic [3:0] S_ERR   = 4'd3;
    localparam logic [3:0] S_MUL_V = 4'd4;
    localparam logic [3:0] S_VEL   = 4'd5;
    localparam logic [3:0] S_MUL_D = 4'd6;
    localparam logic [3:0] S_DISP  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic signed [31:0]        r_x;
    logic signed [DW-1:0]      r_filt;
    logic signed [DW-1:0]      r_err;
    logic signed [31:0]        r_vel;
    logic signed [31:0]        r_disp;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_ovalid;
    logic [127:0]              r_odata;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [30:0]               vel_lim;
    t_wide                     prod_w;
    t_wide                     filt_next;
    t_wide                     err_next;
    t_wide                     vel_next;
    t_wide                     disp_next;
    logic                      out_free;

    assign out_free = !r_ovalid || m_axis_tready;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;
    assign vel_lim  = (i_cfg.velocity_limit < VEL_FLOOR) ? VEL_FLOOR : i_cfg.velocity_limit;
    assign prod_w   = t_wide'(r_prod);

    assign filt_next = t_wide'(r_filt) + ((prod_w + RND16) >>> 16);
    assign err_next  = t_wide'(i_cfg.desired_force) - t_wide'(r_filt);
    assign vel_next  = (prod_w + RND16) >>> 16;
    assign disp_next = t_wide'(r_disp) + ((prod_w + RND32) >>> 32);

    always_comb begin
        unique case (r_state)
            S_MUL_F: begin
                mul_a = MUL_W'(r_x) - MUL_W'(r_filt);
                mul_b = MUL_W'($signed({1'b0, i_cfg.filter_alpha}));
            end
            S_MUL_V: begin
                mul_a = MUL_W'(r_err);
                mul_b = MUL_W'($signed({1'b0, i_cfg.adm_gain}));
            end
            S_MUL_D: begin
                mul_a = MUL_W'($signed({1'b0, i_cfg.tick_period}));
                mul_b = MUL_W'(r_vel);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_head.valid) n_state = S_MUL_F;
            S_MUL_F: n_state = S_FILT;
            S_FILT:  n_state = S_ERR;
            S_ERR:   n_state = S_MUL_V;
            S_MUL_V: n_state = S_VEL;
            S_VEL:   n_state = S_MUL_D;
            S_MUL_D: n_state = S_DISP;
            S_DISP:  n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL_F || r_state == S_MUL_V || r_state == S_MUL_D) begin
            r_prod <= PROD_W'(mul_a * mul_b);
        end
        if (o_pop) begin
            r_x <= i_head.item.force_sample;
        end
        if (r_state == S_ERR) begin
            r_err <= sat_dw(err_next);
        end
        if (r_state == S_VEL) begin
            r_vel <= clamp_sym(vel_next, vel_lim);
        end
        if (r_state == S_OUT && out_free) begin
            r_odata <= {r_disp, r_vel, 32'(r_err), 32'(r_filt)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filt   <= '0;
            r_disp   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_head.item.restart) begin
                r_filt <= sat_dw(t_wide'(i_head.item.force_sample));
                r_disp <= '0;
            end else if (r_state == S_FILT) begin
                r_filt <= sat_dw(filt_next);
            end else if (r_state == S_DISP) begin
                r_disp <= clamp_sym(disp_next, i_cfg.displacement_limit);
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

FILE: hdl/normal_force_admittance_loop.sv
// Normal-force admittance loop: each input item is one force sample (with a restart flag in
// tuser) and yields one result item holding the filtered force, the saturated force error,
// the clamped velocity and the clamped displacement. Items enter a two-entry queue and are
// processed one at a time by a sequencer around a single shared 33 x 33 multiplier, which is
// used three times per item. The sequencer takes a new item from the queue only once the
// result of the previous one has been loaded into the output register, and that load is
// held up while an earlier result still waits in the output register.
// Registers are written through the configuration channel, which is always ready, and must
// only be changed while no item is in flight.
module normal_force_admittance_loop
    import nfal_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // [31:0] force_sample
    input  logic [0:0]   s_axis_tuser,  // [0] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] filtered_force, [63:32] error,
    // [95:64] velocity, [127:96] normal_displacement
    output logic [127:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    t_cfg       r_cfg;
    t_queue_out head;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.desired_force      <= 32'sd327680;
            r_cfg.filter_alpha       <= 17'd7907;
            r_cfg.tick_period        <= 32'd4294967;
            r_cfg.adm_gain           <= 31'd53687;
            r_cfg.velocity_limit     <= 31'd5368709;
            r_cfg.displacement_limit <= 31'd5368709;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DESIRED_FORCE:      r_cfg.desired_force      <= $signed(i_cfg_data);
                CFG_FILTER_ALPHA:       r_cfg.filter_alpha       <= i_cfg_data[16:0];
                CFG_TICK_PERIOD:        r_cfg.tick_period        <= i_cfg_data;
                CFG_ADM_GAIN:           r_cfg.adm_gain           <= i_cfg_data[30:0];
                CFG_VELOCITY_LIMIT:     r_cfg.velocity_limit     <= i_cfg_data[30:0];
                CFG_DISPLACEMENT_LIMIT: r_cfg.displacement_limit <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    nfal_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head        (head),
        .i_pop         (pop)
    );

    nfal_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
